/* sv/date_countdown_days_core_macros.svh */
// Assertion helpers shared by the RTL; they expect clk and rst in scope.
`ifndef DATE_COUNTDOWN_DAYS_CORE_MACROS_SVH
`define DATE_COUNTDOWN_DAYS_CORE_MACROS_SVH

// Same-cycle implication.
`define DCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dcd_pkg.sv */
package dcd_pkg;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 16;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd1970;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd2099;
  localparam logic [YEAR_W-1:0] YEAR_NOLEAP = 12'd2100;

  typedef enum logic [STATUS_W-1:0] {
    ST_OFF    = 3'd0,
    ST_NOSYNC = 3'd1,
    ST_TODAY  = 3'd2,
    ST_NEXT   = 3'd3,
    ST_UNTIL  = 3'd4,
    ST_SINCE  = 3'd5
  } status_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // valid for years 1970..2100
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != YEAR_NOLEAP);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] s;
    unique case (m)
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m);
    if (m == 4'd2 && is_leap(y)) begin
      return 5'd29;
    end
    return month_len(m);
  endfunction

  function automatic date_t clamp_date(input logic [YEAR_W-1:0] y,
                                       input logic [MONTH_W-1:0] m,
                                       input logic [DAY_W-1:0] d);
    date_t r;
    logic [DAY_W-1:0] dim;
    r.year  = (y < YEAR_MIN) ? YEAR_MIN : ((y > YEAR_MAX) ? YEAR_MAX : y);
    r.month = (m == 4'd0) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);
    dim     = month_days(r.year, r.month);
    r.day   = (d == 5'd0) ? 5'd1 : ((d > dim) ? dim : d);
    return r;
  endfunction

  // Feb 29 falls on Feb 28 in a non-leap year
  function automatic logic [DAY_W-1:0] yearly_day(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m,
                                                  input logic [DAY_W-1:0] d);
    if (m == 4'd2 && d == 5'd29 && !is_leap(y)) begin
      return 5'd28;
    end
    return d;
  endfunction

  // days since 1970-01-01, year 1970..2100
  function automatic logic [COUNT_W-1:0] day_number(input logic [YEAR_W-1:0] y,
                                                    input logic [MONTH_W-1:0] m,
                                                    input logic [DAY_W-1:0] d);
    logic [7:0]         ofs;
    logic [7:0]         ofs1;
    logic [COUNT_W-1:0] n;
    ofs  = 8'(y - YEAR_MIN);
    ofs1 = ofs + 8'd1;
    n = COUNT_W'(ofs) * COUNT_W'(365) + COUNT_W'(ofs1[7:2])
        + COUNT_W'(month_start(m)) + COUNT_W'(d) - COUNT_W'(1);
    if (m > 4'd2 && is_leap(y)) begin
      n = n + COUNT_W'(1);
    end
    return n;
  endfunction

endpackage

/* sv/dcd_in_if.sv */
interface dcd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        clock_valid;
  logic [dcd_pkg::YEAR_W-1:0]  cur_year;
  logic [dcd_pkg::MONTH_W-1:0] today_month;
  logic [dcd_pkg::DAY_W-1:0]   today_day;
  logic                        event_enabled;
  logic                        event_yearly;
  logic [dcd_pkg::YEAR_W-1:0]  event_year;
  logic [dcd_pkg::MONTH_W-1:0] event_month;
  logic [dcd_pkg::DAY_W-1:0]   event_day;

  modport source (
    output valid, clock_valid, cur_year, today_month, today_day,
           event_enabled, event_yearly, event_year, event_month, event_day,
    input  ready
  );

  modport sink (
    input  valid, clock_valid, cur_year, today_month, today_day,
           event_enabled, event_yearly, event_year, event_month, event_day,
    output ready
  );
endinterface

/* sv/dcd_out_if.sv */
interface dcd_out_if;
  logic                         valid;
  logic                         ready;
  logic [dcd_pkg::STATUS_W-1:0] status;
  logic [dcd_pkg::COUNT_W-1:0]  day_count;

  modport source (
    output valid, status, day_count,
    input  ready
  );

  modport sink (
    input  valid, status, day_count,
    output ready
  );
endinterface

/* sv/date_countdown_days_core.sv */
// Countdown to a stored event date. Each transaction on item carries today's
// date, a clock-synced flag and one event; one transaction on result follows
// with the status and the day count. The block takes one item per cycle while
// result is taken or empty. The accepting edge loads the input register; the
// result register loads from it whenever result is taken or empty. The date
// clamping and day-number arithmetic sit between the two registers. Both
// registers advance together whenever result is taken or empty, so item.ready
// follows result.ready in the same cycle; a full input register with a stalled
// result holds item.ready low.
`include "date_countdown_days_core_macros.svh"

module date_countdown_days_core (
  input  logic       clk,
  input  logic       rst,
  dcd_in_if.sink     item,
  dcd_out_if.source  result
);

  logic                        s1_valid;
  logic                        s1_clock_valid;
  logic                        s1_enabled;
  logic                        s1_yearly;
  logic [dcd_pkg::YEAR_W-1:0]  s1_cur_year;
  logic [dcd_pkg::MONTH_W-1:0] s1_today_month;
  logic [dcd_pkg::DAY_W-1:0]   s1_today_day;
  logic [dcd_pkg::YEAR_W-1:0]  s1_event_year;
  logic [dcd_pkg::MONTH_W-1:0] s1_event_month;
  logic [dcd_pkg::DAY_W-1:0]   s1_event_day;

  logic                         s2_load;
  dcd_pkg::date_t               today;
  dcd_pkg::date_t               evt;
  logic [dcd_pkg::YEAR_W-1:0]   year_next;
  logic [dcd_pkg::COUNT_W-1:0]  now_num;
  logic [dcd_pkg::COUNT_W:0]    delta_once;
  logic [dcd_pkg::COUNT_W:0]    delta_this;
  logic [dcd_pkg::COUNT_W:0]    delta_next;
  logic [dcd_pkg::COUNT_W:0]    delta_yearly;
  logic [dcd_pkg::COUNT_W:0]    delta_neg;
  dcd_pkg::status_t             status_next;
  logic [dcd_pkg::COUNT_W-1:0]  day_count_next;

  assign s2_load    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (item.ready) begin
        s1_valid <= item.valid;
      end
      if (!result.valid || result.ready) begin
        result.valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_clock_valid <= item.clock_valid;
      s1_enabled     <= item.event_enabled;
      s1_yearly      <= item.event_yearly;
      s1_cur_year    <= item.cur_year;
      s1_today_month <= item.today_month;
      s1_today_day   <= item.today_day;
      s1_event_year  <= item.event_year;
      s1_event_month <= item.event_month;
      s1_event_day   <= item.event_day;
    end
    if (s2_load) begin
      result.status    <= status_next;
      result.day_count <= day_count_next;
    end
  end

  always_comb begin
    today     = dcd_pkg::clamp_date(s1_cur_year, s1_today_month, s1_today_day);
    evt       = dcd_pkg::clamp_date(s1_event_year, s1_event_month, s1_event_day);
    year_next = today.year + 12'd1;
    now_num   = dcd_pkg::day_number(today.year, today.month, today.day);

    delta_once = {1'b0, dcd_pkg::day_number(evt.year, evt.month, evt.day)}
                 - {1'b0, now_num};
    delta_this = {1'b0, dcd_pkg::day_number(today.year, evt.month,
                   dcd_pkg::yearly_day(today.year, evt.month, evt.day))}
                 - {1'b0, now_num};
    delta_next = {1'b0, dcd_pkg::day_number(year_next, evt.month,
                   dcd_pkg::yearly_day(year_next, evt.month, evt.day))}
                 - {1'b0, now_num};
    delta_yearly = delta_this[dcd_pkg::COUNT_W] ? delta_next : delta_this;
    delta_neg    = '0 - delta_once;

    status_next    = dcd_pkg::ST_OFF;
    day_count_next = '0;
    priority if (!s1_enabled) begin
      status_next = dcd_pkg::ST_OFF;
    end else if (!s1_clock_valid) begin
      status_next = dcd_pkg::ST_NOSYNC;
    end else if (s1_yearly) begin
      if (delta_yearly == '0) begin
        status_next = dcd_pkg::ST_TODAY;
      end else begin
        status_next    = dcd_pkg::ST_NEXT;
        day_count_next = delta_yearly[dcd_pkg::COUNT_W-1:0];
      end
    end else if (delta_once == '0) begin
      status_next = dcd_pkg::ST_TODAY;
    end else if (!delta_once[dcd_pkg::COUNT_W]) begin
      status_next    = dcd_pkg::ST_UNTIL;
      day_count_next = delta_once[dcd_pkg::COUNT_W-1:0];
    end else begin
      status_next    = dcd_pkg::ST_SINCE;
      day_count_next = delta_neg[dcd_pkg::COUNT_W-1:0];
    end
  end

  `DCD_ASSERT_NOW(a_zero_count, result.valid && (result.status == dcd_pkg::ST_OFF || result.status == dcd_pkg::ST_NOSYNC || result.status == dcd_pkg::ST_TODAY), result.day_count == '0, "nonzero count for a status without count")
  `DCD_ASSERT_NOW(a_next_range, result.valid && result.status == dcd_pkg::ST_NEXT, result.day_count != '0 && result.day_count <= 16'd366, "yearly count out of range")
  `DCD_ASSERT_NEXT(a_hold_s1, s1_valid && !s2_load, s1_valid, "stalled transaction dropped")
  `DCD_ASSERT_NOW(a_ready_low, !item.ready, s1_valid && result.valid && !result.ready, "item stalled without back-pressure")
  `DCD_ASSERT_NEXT(a_result_follows, s2_load, result.valid, "loaded result not presented")

endmodule

/* tb/sv/countdown_checker.sv */
`timescale 1ns / 1ps

module countdown_checker (
  input  logic clk,
  input  logic rst,
  dcd_in_if    item,
  dcd_out_if   result,
  output int   fail_count,
  output int   awaited_count
);

  localparam int FIRST_YEAR = 1970;
  localparam int LAST_YEAR  = 2099;
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    dcd_pkg::status_t status;
    logic [15:0]      days;
    string            origin;
  } countdown_t;

  countdown_t awaited[$];

  initial begin
    fail_count    = 0;
    awaited_count = 0;
  end

  function automatic bit leap_of(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in(int y, int m);
    if (m == 2 && leap_of(y)) begin
      return 29;
    end
    return MONTH_DAYS[m-1];
  endfunction

  function automatic int epoch_day(int y, int m, int d);
    int n;
    n = 0;
    for (int yy = FIRST_YEAR; yy < y; yy++) begin
      n += leap_of(yy) ? 366 : 365;
    end
    for (int mm = 1; mm < m; mm++) begin
      n += days_in(y, mm);
    end
    return n + d - 1;
  endfunction

  function automatic void clamp_civil(input int y, input int m, input int d,
                                      output int cy, output int cm, output int cd);
    cy = (y < FIRST_YEAR) ? FIRST_YEAR : ((y > LAST_YEAR) ? LAST_YEAR : y);
    cm = (m < 1) ? 1 : ((m > 12) ? 12 : m);
    cd = (d < 1) ? 1 : ((d > days_in(cy, cm)) ? days_in(cy, cm) : d);
  endfunction

  // Feb 29 falls back to Feb 28 outside leap years
  function automatic int anniversary_day(int y, int m, int d);
    return (m == 2 && d == 29 && !leap_of(y)) ? 28 : d;
  endfunction

  function automatic countdown_t countdown_of(
    logic cv, logic [11:0] ty, logic [3:0] tm, logic [4:0] td,
    logic en, logic yl, logic [11:0] ey, logic [3:0] em, logic [4:0] ed);
    countdown_t r;
    int cty, ctm, ctd, cey, cem, ced, now, delta;
    r.status = dcd_pkg::ST_OFF;
    r.days   = '0;
    r.origin = $sformatf("cv=%0b today=%0d-%0d-%0d en=%0b yearly=%0b event=%0d-%0d-%0d",
                         cv, ty, tm, td, en, yl, ey, em, ed);
    if (!en) begin
      return r;
    end
    if (!cv) begin
      r.status = dcd_pkg::ST_NOSYNC;
      return r;
    end
    clamp_civil(int'(ty), int'(tm), int'(td), cty, ctm, ctd);
    clamp_civil(int'(ey), int'(em), int'(ed), cey, cem, ced);
    now = epoch_day(cty, ctm, ctd);
    if (yl) begin
      delta = epoch_day(cty, cem, anniversary_day(cty, cem, ced)) - now;
      if (delta < 0) begin
        delta = epoch_day(cty + 1, cem, anniversary_day(cty + 1, cem, ced)) - now;
      end
      r.status = (delta == 0) ? dcd_pkg::ST_TODAY : dcd_pkg::ST_NEXT;
      r.days   = 16'(delta);
    end else begin
      delta = epoch_day(cey, cem, ced) - now;
      if (delta == 0) begin
        r.status = dcd_pkg::ST_TODAY;
      end else if (delta > 0) begin
        r.status = dcd_pkg::ST_UNTIL;
        r.days   = 16'(delta);
      end else begin
        r.status = dcd_pkg::ST_SINCE;
        r.days   = 16'(-delta);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    countdown_t want;
    if (!rst) begin
      if (item.valid && item.ready) begin
        awaited.push_back(countdown_of(item.clock_valid, item.cur_year, item.today_month,
                                       item.today_day, item.event_enabled, item.event_yearly,
                                       item.event_year, item.event_month, item.event_day));
      end
      if (result.valid && result.ready) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction status=%0d day_count=%0d",
                                    result.status, result.day_count));
        end else begin
          want = awaited.pop_front();
          if (result.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %s for %s",
                                      result.status, want.status.name(), want.origin));
          end
          if (result.day_count !== want.days) begin
            report_mismatch($sformatf("day_count %0d, want %0d for %s",
                                      result.day_count, want.days, want.origin));
          end
        end
      end
    end
    awaited_count = awaited.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   awaited_count;
  int   cycles      = 0;
  int   stall_left  = 0;
  int   sink_style  = 0;
  bit   calm_source = 1'b0;

  dcd_in_if  item ();
  dcd_out_if result ();

  date_countdown_days_core DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  countdown_checker countdown_chk (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .result        (result),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("date_countdown_days_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycles % 500 == 0) begin
      sink_style <= $urandom_range(0, 2);
    end
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      result.ready  <= 1'b0;
    end else begin
      case (sink_style)
        0: result.ready <= 1'b1;
        1: result.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 39) == 0) begin
            stall_left   <= $urandom_range(10, 60);
            result.ready <= 1'b0;
          end else begin
            result.ready <= ($urandom_range(0, 1) == 1);
          end
        end
      endcase
    end
  end

  function automatic int gap_cycles();
    int r;
    if (calm_source) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic offer(input logic cv, input int ty, input int tm, input int td,
                       input logic en, input logic yl,
                       input int ey, input int em, input int ed);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.clock_valid   <= cv;
    item.cur_year      <= 12'(ty);
    item.today_month   <= 4'(tm);
    item.today_day     <= 5'(td);
    item.event_enabled <= en;
    item.event_yearly  <= yl;
    item.event_year    <= 12'(ey);
    item.event_month   <= 4'(em);
    item.event_day     <= 5'(ed);
    item.valid         <= 1'b1;
    do @(posedge clk); while (!item.ready);
  endtask

  task automatic pick_date(output int y, output int m, output int d);
    y = $urandom_range(1970, 2099);
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
  endtask

  task automatic random_item();
    int   r, ty, tm, td, ey, em, ed;
    logic cv, en, yl;
    r  = $urandom_range(0, 99);
    en = (r >= 5);
    cv = (r < 5) ? logic'($urandom_range(0, 1)) : (r >= 10);
    if ($urandom_range(0, 9) == 0) begin
      ty = $urandom_range(0, 4095);
      tm = $urandom_range(0, 15);
      td = $urandom_range(0, 31);
    end else begin
      pick_date(ty, tm, td);
    end
    yl = $urandom_range(0, 1);
    r  = $urandom_range(0, 99);
    if (r < 40) begin
      ey = ty + $urandom_range(0, 2) - 1;
      em = tm + $urandom_range(0, 2) - 1;
      ed = td + $urandom_range(0, 6) - 3;
      if (ey < 0) ey = 0;
      if (em < 0) em = 0;
      if (ed < 0) ed = 0;
    end else if (r < 48) begin
      ey = 4 * $urandom_range(493, 524);
      em = 2;
      ed = 29;
    end else if (r < 85) begin
      pick_date(ey, em, ed);
    end else begin
      ey = $urandom_range(0, 4095);
      em = $urandom_range(0, 15);
      ed = $urandom_range(0, 31);
    end
    offer(cv, ty, tm, td, en, yl, ey, em, ed);
  endtask

  initial begin
    rst                = 1'b1;
    item.valid         = 1'b0;
    item.clock_valid   = 1'b0;
    item.cur_year      = '0;
    item.today_month   = '0;
    item.today_day     = '0;
    item.event_enabled = 1'b0;
    item.event_yearly  = 1'b0;
    item.event_year    = '0;
    item.event_month   = '0;
    item.event_day     = '0;
    result.ready       = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    offer(0, 2024, 5, 5, 0, 0, 2024, 5, 5);
    offer(0, 2024, 5, 5, 1, 0, 2024, 5, 5);
    offer(1, 2024, 5, 5, 1, 0, 2024, 5, 5);
    offer(1, 1970, 1, 1, 1, 0, 2099, 12, 31);
    offer(1, 2099, 12, 31, 1, 0, 1970, 1, 1);
    offer(1, 2024, 5, 5, 1, 1, 2000, 5, 5);
    offer(1, 2024, 5, 5, 1, 1, 1999, 5, 6);
    offer(1, 2024, 5, 5, 1, 1, 1999, 5, 4);
    offer(1, 2023, 1, 10, 1, 1, 2024, 2, 29);
    offer(1, 2024, 1, 10, 1, 1, 2000, 2, 29);
    offer(1, 2099, 12, 31, 1, 1, 2000, 1, 1);
    offer(1, 2099, 3, 1, 1, 1, 2096, 2, 29);
    offer(1, 2024, 6, 1, 1, 0, 0, 0, 0);
    offer(1, 2024, 6, 1, 1, 0, 4095, 15, 31);
    offer(1, 0, 0, 0, 1, 0, 2024, 6, 1);
    offer(1, 4095, 15, 31, 1, 0, 2024, 6, 1);
    offer(1, 2023, 2, 31, 1, 0, 2023, 2, 30);
    offer(1, 2000, 2, 30, 1, 0, 2000, 2, 29);
    offer(1, 2024, 4, 31, 1, 0, 2024, 4, 30);
    offer(1, 2024, 12, 31, 1, 1, 1969, 1, 1);
    offer(1, 2024, 2, 29, 1, 1, 2023, 3, 0);
    offer(0, 1970, 1, 1, 0, 1, 0, 0, 0);
    offer(1, 2099, 12, 31, 1, 1, 2099, 12, 31);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        calm_source = ($urandom_range(0, 3) == 0);
      end
      random_item();
    end
    item.valid <= 1'b0;

    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("date_countdown_days_core test passed");
    end else begin
      $display("date_countdown_days_core test failed");
    end
    $finish;
  end

endmodule
